/* hdl/ip_allow_deny_table_unit_macros.svh */
// assertion macros used by the rtl file iadt_seq.sv
`ifndef IP_ALLOW_DENY_TABLE_UNIT_MACROS_SVH
`define IP_ALLOW_DENY_TABLE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked only outside reset
`define IADT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define IADT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IADT_ASSERT(lbl, prop, msg)
`define IADT_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* hdl/iadt_pkg.sv */
package iadt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ADDR_W      = IDX_W + 1;
    localparam int MEM_DEPTH   = 2 ** ADDR_W;
    localparam int KEY_W       = 32;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    localparam logic [CFG_INDEX_W-1:0] REG_ALLOW_ENABLE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_DENY_ENABLE  = CFG_INDEX_W'(1);

    localparam logic [2:0] KIND_CHECK        = 3'd0;
    localparam logic [2:0] KIND_ADD_ALLOW    = 3'd1;
    localparam logic [2:0] KIND_ADD_DENY     = 3'd2;
    localparam logic [2:0] KIND_REMOVE_ALLOW = 3'd3;
    localparam logic [2:0] KIND_REMOVE_DENY  = 3'd4;

    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_UNCHANGED = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    localparam logic TBL_ALLOW = 1'b0;
    localparam logic TBL_DENY  = 1'b1;

    typedef struct packed {
        logic [2:0]       kind;
        logic [KEY_W-1:0] address;
    } in_beat_t;

    typedef struct packed {
        logic       allowed;
        logic [1:0] status;
    } out_beat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic              clr_en;
        logic [ADDR_W-1:0] upd_addr;
        logic [KEY_W-1:0]  wr_key;
    } store_ctl_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             valid;
    } store_rd_t;

endpackage

/* hdl/iadt_key_store.sv */
module iadt_key_store
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  iadt_pkg::store_ctl_t   ctl,
    output iadt_pkg::store_rd_t    rd
);

    // allow table in the lower half, deny table in the upper half
    logic [iadt_pkg::KEY_W-1:0]     mem [iadt_pkg::MEM_DEPTH];
    logic [iadt_pkg::MEM_DEPTH-1:0] valid_reg;
    logic [iadt_pkg::KEY_W-1:0]     rd_key_reg;
    logic                           rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.upd_addr] <= ctl.wr_key;
        end
        if (ctl.rd_en)
        begin
            rd_key_reg   <= mem[ctl.rd_addr];
            rd_valid_reg <= valid_reg[ctl.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ctl.wr_en)
            begin
                valid_reg[ctl.upd_addr] <= 1'b1;
            end
            if (ctl.clr_en)
            begin
                valid_reg[ctl.upd_addr] <= 1'b0;
            end
        end
    end

    assign rd.key   = rd_key_reg;
    assign rd.valid = rd_valid_reg;

endmodule

/* hdl/iadt_seq.sv */
`include "ip_allow_deny_table_unit_macros.svh"

module iadt_seq
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  iadt_pkg::in_beat_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output iadt_pkg::out_beat_t   out_data,
    input  logic                  allow_enable,
    input  logic                  deny_enable,
    output iadt_pkg::store_ctl_t  ctl,
    input  iadt_pkg::store_rd_t   rd
);

    iadt_pkg::seq_state_t          state_reg, state_next;
    iadt_pkg::in_beat_t            item_reg;
    logic                          tbl_reg;
    logic [iadt_pkg::IDX_W-1:0]    idx_reg;
    logic                          rd_pend_reg;
    logic                          rd_tbl_reg;
    logic [iadt_pkg::IDX_W-1:0]    rd_idx_reg;
    logic                          allow_hit_reg;
    logic                          deny_hit_reg;
    logic [iadt_pkg::IDX_W-1:0]    hit_idx_reg;
    logic                          free_found_reg;
    logic [iadt_pkg::IDX_W-1:0]    free_idx_reg;
    logic                          out_valid_reg;
    iadt_pkg::out_beat_t           out_reg;

    logic                          accept;
    logic                          finish_go;
    logic                          tgt;
    logic                          tgt_hit;
    logic                          match;
    logic                          do_wr;
    logic                          do_clr;
    iadt_pkg::out_beat_t           result;

    assign in_ready  = (state_reg == iadt_pkg::ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign finish_go = (state_reg == iadt_pkg::ST_FINISH) && (!out_valid_reg || out_ready);

    // the one shared comparator, fed from the registered memory read
    assign match = rd_pend_reg && rd.valid && (rd.key == item_reg.address);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            iadt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = iadt_pkg::ST_SCAN;
                end
            end
            iadt_pkg::ST_SCAN:
            begin
                if (tbl_reg == iadt_pkg::TBL_DENY && idx_reg == iadt_pkg::LAST_IDX)
                begin
                    state_next = iadt_pkg::ST_DRAIN;
                end
            end
            iadt_pkg::ST_DRAIN:
            begin
                state_next = iadt_pkg::ST_FINISH;
            end
            iadt_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = iadt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = iadt_pkg::ST_IDLE;
            end
        endcase
    end

    // result of the item once both tables are scanned
    always_comb
    begin
        tgt            = item_reg.kind inside {iadt_pkg::KIND_ADD_DENY,
                                               iadt_pkg::KIND_REMOVE_DENY};
        tgt_hit        = tgt ? deny_hit_reg : allow_hit_reg;
        result.allowed = 1'b0;
        result.status  = iadt_pkg::STAT_DONE;
        do_wr          = 1'b0;
        do_clr         = 1'b0;
        case (item_reg.kind)
            iadt_pkg::KIND_CHECK:
            begin
                result.allowed = (allow_enable && allow_hit_reg) ||
                                 !(deny_enable && deny_hit_reg);
            end
            iadt_pkg::KIND_ADD_ALLOW, iadt_pkg::KIND_ADD_DENY:
            begin
                if (tgt_hit)
                begin
                    result.status = iadt_pkg::STAT_UNCHANGED;
                end
                else if (free_found_reg)
                begin
                    do_wr = 1'b1;
                end
                else
                begin
                    result.status = iadt_pkg::STAT_FULL;
                end
            end
            iadt_pkg::KIND_REMOVE_ALLOW, iadt_pkg::KIND_REMOVE_DENY:
            begin
                if (tgt_hit)
                begin
                    do_clr = 1'b1;
                end
                else
                begin
                    result.status = iadt_pkg::STAT_UNCHANGED;
                end
            end
            default:
            begin
                result.status = iadt_pkg::STAT_UNCHANGED;
            end
        endcase
    end

    always_comb
    begin
        ctl.rd_en    = (state_reg == iadt_pkg::ST_SCAN);
        ctl.rd_addr  = {tbl_reg, idx_reg};
        ctl.wr_en    = finish_go && do_wr;
        ctl.clr_en   = finish_go && do_clr;
        ctl.upd_addr = {tgt, tgt_hit ? hit_idx_reg : free_idx_reg};
        ctl.wr_key   = item_reg.address;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= iadt_pkg::ST_IDLE;
            tbl_reg        <= iadt_pkg::TBL_ALLOW;
            idx_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            allow_hit_reg  <= 1'b0;
            deny_hit_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_pend_reg <= (state_reg == iadt_pkg::ST_SCAN);
            if (accept)
            begin
                tbl_reg        <= iadt_pkg::TBL_ALLOW;
                idx_reg        <= '0;
                allow_hit_reg  <= 1'b0;
                deny_hit_reg   <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (state_reg == iadt_pkg::ST_SCAN)
                begin
                    if (idx_reg == iadt_pkg::LAST_IDX)
                    begin
                        idx_reg <= '0;
                        tbl_reg <= iadt_pkg::TBL_DENY;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                if (match && rd_tbl_reg == iadt_pkg::TBL_ALLOW)
                begin
                    allow_hit_reg <= 1'b1;
                end
                if (match && rd_tbl_reg == iadt_pkg::TBL_DENY)
                begin
                    deny_hit_reg <= 1'b1;
                end
                // lowest free slot of the target table
                if (rd_pend_reg && rd_tbl_reg == tgt && !rd.valid && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
            if (finish_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
        rd_tbl_reg <= tbl_reg;
        rd_idx_reg <= idx_reg;
        if (match && rd_tbl_reg == tgt)
        begin
            hit_idx_reg <= rd_idx_reg;
        end
        if (rd_pend_reg && rd_tbl_reg == tgt && !rd.valid && !free_found_reg)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        if (finish_go)
        begin
            out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `IADT_ASSERT(a_accept_starts_scan,
        accept |=> state_reg == iadt_pkg::ST_SCAN,
        "accepted beat did not start a scan")
    `IADT_ASSERT(a_no_wr_and_clr,
        !(ctl.wr_en && ctl.clr_en),
        "table write and clear in the same cycle")
    `IADT_ASSERT(a_full_only_on_add,
        finish_go && result.status == iadt_pkg::STAT_FULL |->
            (item_reg.kind == iadt_pkg::KIND_ADD_ALLOW ||
             item_reg.kind == iadt_pkg::KIND_ADD_DENY),
        "table full reported for a non-add beat")
    `IADT_ASSERT(a_allowed_only_on_check,
        finish_go && result.allowed |-> item_reg.kind == iadt_pkg::KIND_CHECK,
        "allowed set for a non-check beat")
    `IADT_ASSERT(a_no_read_in_idle,
        state_reg == iadt_pkg::ST_IDLE |-> !rd_pend_reg,
        "read pending while idle")
    `IADT_ASSERT_ALWAYS(a_reset_clears_out,
        !rst_n |=> !out_valid_reg,
        "result valid right after reset")

endmodule

/* hdl/ip_allow_deny_table_unit.sv */
// ipv4 allow / deny list with one 32-bit key per entry
// in channel: in_valid / in_ready with in_data (kind, address); kind selects
//   check, add to allow, add to deny, remove from allow, remove from deny
// out channel: out_valid / out_ready with out_data (allowed, status), one
//   result beat for every input beat, in order
// cfg channel: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0 is
//   allow_enable, index 1 is deny_enable, low data bit kept, others ignored;
//   cfg_ready is always high
// each beat scans all 2*TABLE_DEPTH entries through one comparator reading
//   the key memory one entry a cycle, then passes a drain and a finish step;
//   out_valid is registered from the finish step, and a new beat is taken
//   only once the finish step is done; in_ready is low meanwhile
// the result sits in an output register: a new beat may be taken while it
//   waits, and a stalled receiver holds the next result in the final step
// reset clears all valid marks of both tables and sets both enables to 1;
//   no clearing pass is needed
module ip_allow_deny_table_unit
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  iadt_pkg::in_beat_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output iadt_pkg::out_beat_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [iadt_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [iadt_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic                  allow_enable_reg;
    logic                  deny_enable_reg;
    iadt_pkg::store_ctl_t  ctl;
    iadt_pkg::store_rd_t   rd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_enable_reg <= 1'b1;
            deny_enable_reg  <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                iadt_pkg::REG_ALLOW_ENABLE: allow_enable_reg <= cfg_data[0];
                iadt_pkg::REG_DENY_ENABLE:  deny_enable_reg  <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    iadt_key_store u_key_store
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .rd    (rd)
    );

    iadt_seq u_seq
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .allow_enable (allow_enable_reg),
        .deny_enable  (deny_enable_reg),
        .ctl          (ctl),
        .rd           (rd)
    );

endmodule
